### rtl/core/lprp_pkg.sv
// Shared types and constants of the LED pattern record and playback block.
// Used by every module in rtl/core; depends on nothing.
package lprp_pkg;

    localparam int LAMP_W  = 3;
    localparam int OP_W    = 3;
    localparam int PRESS_W = 7;

    localparam logic [LAMP_W-1:0]  LAMPS           = 3'd5;
    localparam logic [PRESS_W-1:0] MAX_PRESSES_RST = 7'd45;

    // Opcodes carried on the input channel's tuser.
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_EDGE  = 3'd1;
    localparam logic [OP_W-1:0] OP_START = 3'd2;
    localparam logic [OP_W-1:0] OP_FAST  = 3'd3;
    localparam logic [OP_W-1:0] OP_SLOW  = 3'd4;
    localparam logic [OP_W-1:0] OP_REV   = 3'd5;

    // What happens to the delay of an entry as it wraps around the ring.
    typedef enum logic [1:0] {
        ROT_PLAIN = 2'd0,
        ROT_FAST  = 2'd1,
        ROT_SLOW  = 2'd2
    } rot_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ROTATE = 3'b010,
        ST_LOAD   = 3'b100
    } state_t;

    // Commands broadcast from the sequencer to every cell of the ring.
    typedef struct packed {
        logic shift;
        logic flip;
        logic append;
    } cell_ctrl_t;

endpackage

### rtl/core/lprp_cell.sv
// One storage cell of the entry ring: on bit, lamp index and delay.
// Depends on lprp_pkg for the control struct and lamp width.
module lprp_cell #(
    parameter int DELAY_BITS = 20,
    parameter int IDX_W      = 7,
    parameter int CNT_W      = 8,
    parameter int INDEX      = 0
) (
    input  logic                          aclk,
    input  lprp_pkg::cell_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]              count,
    input  logic [IDX_W-1:0]              last_idx,
    input  logic                          app_on,
    input  logic [lprp_pkg::LAMP_W-1:0]   app_lamp,
    input  logic [DELAY_BITS-1:0]         app_delay,
    input  logic                          nxt_on,
    input  logic [lprp_pkg::LAMP_W-1:0]   nxt_lamp,
    input  logic [DELAY_BITS-1:0]         nxt_delay,
    input  logic                          wrap_on,
    input  logic [lprp_pkg::LAMP_W-1:0]   wrap_lamp,
    input  logic [DELAY_BITS-1:0]         wrap_delay,
    output logic                          on,
    output logic [lprp_pkg::LAMP_W-1:0]   lamp,
    output logic [DELAY_BITS-1:0]         delay
);

    logic                        on_reg, on_next;
    logic [lprp_pkg::LAMP_W-1:0] lamp_reg, lamp_next;
    logic [DELAY_BITS-1:0]       delay_reg, delay_next;

    always_comb begin
        on_next    = on_reg;
        lamp_next  = lamp_reg;
        delay_next = delay_reg;
        if (ctrl.append && count == CNT_W'(INDEX)) begin
            on_next    = app_on;
            lamp_next  = app_lamp;
            delay_next = app_delay;
        end else if (ctrl.shift) begin
            // The last live cell closes the ring by taking the head's entry.
            if (last_idx == IDX_W'(INDEX)) begin
                on_next    = wrap_on;
                lamp_next  = wrap_lamp;
                delay_next = wrap_delay;
            end else begin
                on_next    = nxt_on;
                lamp_next  = nxt_lamp;
                delay_next = nxt_delay;
            end
        end else if (ctrl.flip) begin
            on_next = ~on_reg;
        end
    end

    always_ff @(posedge aclk) begin
        on_reg    <= on_next;
        lamp_reg  <= lamp_next;
        delay_reg <= delay_next;
    end

    assign on    = on_reg;
    assign lamp  = lamp_reg;
    assign delay = delay_reg;

endmodule

### rtl/core/lprp_scale.sv
// Delay scaling unit at the wrap point of the ring: 3/4 or 5/4, truncated,
// the slow-down result saturated. Depends on lprp_pkg for the mode type.
module lprp_scale #(
    parameter int DELAY_BITS = 20
) (
    input  lprp_pkg::rot_mode_t     mode,
    input  logic [DELAY_BITS-1:0]   d,
    output logic [DELAY_BITS-1:0]   q
);

    logic [DELAY_BITS+1:0] x3;
    logic [DELAY_BITS+2:0] x5;

    assign x3 = {1'b0, d, 1'b0} + {2'b00, d};
    assign x5 = {1'b0, d, 2'b00} + {3'b000, d};

    always_comb begin
        case (mode)
            lprp_pkg::ROT_FAST: q = x3[DELAY_BITS+1:2];
            lprp_pkg::ROT_SLOW: q = x5[DELAY_BITS+2] ? '1 : x5[DELAY_BITS+1:2];
            default:            q = d;
        endcase
    end

endmodule

### rtl/core/led_pattern_record_playback.sv
// Top level of the LED pattern record and playback block: sequencer, entry
// ring and output skid stage. Depends on lprp_pkg, lprp_cell and lprp_scale.
//
// The block records button edges of five lamps into a ring of ENTRIES cells
// and replays them cyclically on millisecond ticks. The head cell always holds
// the entry about to be played. A forward playback action shifts the ring one
// place in ROTATE, then loads the next wait from the new head in LOAD. A
// reverse playback action turns the ring back one place by shifting it forward
// through every entry but one. Speed-up and slow-down turn the ring once round:
// every entry passes once through the single scaling unit at the ring's wrap
// point. Reverse flips every stored action without turning the ring. A result
// waits in an output register with a skid stage behind it, so an input
// transaction is still taken while one result is waiting downstream. There is
// no clearing pass after reset; the store is only read below its fill count.
module led_pattern_record_playback #(
    parameter int ENTRIES    = 128,
    parameter int DELAY_BITS = 20
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [2:0] button, [3] pressed
    input  logic [lprp_pkg::OP_W-1:0]       s_tuser,   // [2:0] opcode
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [2:0] lamp, [3] lamp_on
    // Configuration: max_presses.
    input  logic                            cfg_wen,
    input  logic [lprp_pkg::PRESS_W-1:0]    cfg_wdata
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int LW    = lprp_pkg::LAMP_W;

    // Ring contents, one slot per cell.
    logic                  on_w    [ENTRIES];
    logic [LW-1:0]         lamp_w  [ENTRIES];
    logic [DELAY_BITS-1:0] delay_w [ENTRIES];

    logic [DELAY_BITS-1:0] wrap_delay;
    lprp_pkg::cell_ctrl_t  ctrl;

    // Control state.
    lprp_pkg::state_t        state_reg, state_next;
    lprp_pkg::rot_mode_t     mode_reg, mode_next;
    logic                    load_reg, load_next;
    logic [CNT_W-1:0]        rot_reg, rot_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [lprp_pkg::PRESS_W-1:0] release_reg, release_next;
    logic [lprp_pkg::PRESS_W-1:0] max_reg;
    logic [DELAY_BITS-1:0]   elapsed_reg, elapsed_next;
    logic [DELAY_BITS-1:0]   wait_reg, wait_next;
    logic                    playing_reg, playing_next;
    logic                    forward_reg, forward_next;

    // Output register and skid stage.
    logic          out_v_reg, skid_v_reg;
    logic [LW-1:0] out_lamp_reg, skid_lamp_reg;
    logic          out_on_reg, skid_on_reg;

    logic                      s_fire, m_fire;
    logic [lprp_pkg::OP_W-1:0] op;
    logic [LW-1:0]             button;
    logic                      pressed;
    logic                      p_v;
    logic [LW-1:0]             p_lamp;
    logic                      p_on;
    logic [IDX_W-1:0]          last_idx;
    logic [DELAY_BITS-1:0]     head_wait;

    assign op      = s_tuser;
    assign button  = s_tdata[LW-1:0];
    assign pressed = s_tdata[LW];

    assign s_tready = (state_reg == lprp_pkg::ST_IDLE) && !skid_v_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_v_reg && m_tready;

    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    // A zero delay still costs one tick.
    assign head_wait = (delay_w[0] == '0) ? DELAY_BITS'(1) : delay_w[0];

    lprp_scale #(
        .DELAY_BITS (DELAY_BITS)
    ) u_scale (
        .mode (mode_reg),
        .d    (delay_w[0]),
        .q    (wrap_delay)
    );

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        logic                  nxt_on;
        logic [LW-1:0]         nxt_lamp;
        logic [DELAY_BITS-1:0] nxt_delay;

        if (k == ENTRIES - 1) begin : g_tail
            assign nxt_on    = on_w[0];
            assign nxt_lamp  = lamp_w[0];
            assign nxt_delay = wrap_delay;
        end else begin : g_body
            assign nxt_on    = on_w[k+1];
            assign nxt_lamp  = lamp_w[k+1];
            assign nxt_delay = delay_w[k+1];
        end

        lprp_cell #(
            .DELAY_BITS (DELAY_BITS),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .INDEX      (k)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .last_idx   (last_idx),
            .app_on     (pressed),
            .app_lamp   (button),
            .app_delay  (elapsed_reg),
            .nxt_on     (nxt_on),
            .nxt_lamp   (nxt_lamp),
            .nxt_delay  (nxt_delay),
            .wrap_on    (on_w[0]),
            .wrap_lamp  (lamp_w[0]),
            .wrap_delay (wrap_delay),
            .on         (on_w[k]),
            .lamp       (lamp_w[k]),
            .delay      (delay_w[k])
        );
    end

    // Sequencer: decodes one transaction in IDLE, then turns the ring as far as
    // that transaction needs and, after a forward step, loads the next wait.
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        load_next    = load_reg;
        rot_next     = rot_reg;
        count_next   = count_reg;
        release_next = release_reg;
        elapsed_next = elapsed_reg;
        wait_next    = wait_reg;
        playing_next = playing_reg;
        forward_next = forward_reg;
        ctrl         = '0;
        p_v          = 1'b0;
        p_lamp       = button;
        p_on         = pressed;

        unique case (state_reg)
            lprp_pkg::ST_IDLE: begin
                if (s_fire) begin
                    unique case (op) inside
                        lprp_pkg::OP_TICK: begin
                            if (!playing_reg) begin
                                if (elapsed_reg != '1) begin
                                    elapsed_next = elapsed_reg + DELAY_BITS'(1);
                                end
                            end else if (wait_reg > DELAY_BITS'(1)) begin
                                wait_next = wait_reg - DELAY_BITS'(1);
                            end else begin
                                p_v    = 1'b1;
                                p_lamp = lamp_w[0];
                                p_on   = on_w[0];
                                mode_next = lprp_pkg::ROT_PLAIN;
                                if (forward_reg) begin
                                    // Step to the next entry, then wait its delay.
                                    rot_next   = CNT_W'(1);
                                    load_next  = 1'b1;
                                    state_next = lprp_pkg::ST_ROTATE;
                                end else begin
                                    // Wait this entry's delay, then step back one.
                                    wait_next = head_wait;
                                    load_next = 1'b0;
                                    if (count_reg > CNT_W'(1)) begin
                                        rot_next   = count_reg - CNT_W'(1);
                                        state_next = lprp_pkg::ST_ROTATE;
                                    end
                                end
                            end
                        end
                        lprp_pkg::OP_EDGE: begin
                            if (!playing_reg && button < lprp_pkg::LAMPS &&
                                release_reg < max_reg &&
                                count_reg < CNT_W'(ENTRIES)) begin
                                ctrl.append  = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                elapsed_next = '0;
                                if (!pressed) begin
                                    release_next = release_reg + lprp_pkg::PRESS_W'(1);
                                end
                                p_v = 1'b1;
                            end
                        end
                        lprp_pkg::OP_START: begin
                            if (!playing_reg && count_reg != '0) begin
                                playing_next = 1'b1;
                                wait_next    = '0;
                            end
                        end
                        lprp_pkg::OP_FAST, lprp_pkg::OP_SLOW: begin
                            if (playing_reg) begin
                                mode_next  = (op == lprp_pkg::OP_FAST) ?
                                             lprp_pkg::ROT_FAST : lprp_pkg::ROT_SLOW;
                                rot_next   = count_reg;
                                load_next  = 1'b0;
                                state_next = lprp_pkg::ST_ROTATE;
                            end
                        end
                        lprp_pkg::OP_REV: begin
                            if (playing_reg) begin
                                ctrl.flip    = 1'b1;
                                forward_next = ~forward_reg;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            lprp_pkg::ST_ROTATE: begin
                ctrl.shift = 1'b1;
                rot_next   = rot_reg - CNT_W'(1);
                if (rot_reg == CNT_W'(1)) begin
                    state_next = load_reg ? lprp_pkg::ST_LOAD : lprp_pkg::ST_IDLE;
                end
            end
            lprp_pkg::ST_LOAD: begin
                wait_next  = head_wait;
                state_next = lprp_pkg::ST_IDLE;
            end
            default: state_next = lprp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lprp_pkg::ST_IDLE;
            mode_reg    <= lprp_pkg::ROT_PLAIN;
            load_reg    <= 1'b0;
            rot_reg     <= '0;
            count_reg   <= '0;
            release_reg <= '0;
            elapsed_reg <= '0;
            wait_reg    <= '0;
            playing_reg <= 1'b0;
            forward_reg <= 1'b1;
            max_reg     <= lprp_pkg::MAX_PRESSES_RST;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            load_reg    <= load_next;
            rot_reg     <= rot_next;
            count_reg   <= count_next;
            release_reg <= release_next;
            elapsed_reg <= elapsed_next;
            wait_reg    <= wait_next;
            playing_reg <= playing_next;
            forward_reg <= forward_next;
            if (cfg_wen) begin
                max_reg <= cfg_wdata;
            end
        end
    end

    // Output register with a skid stage. A new result only arrives while the
    // skid stage is empty, since s_tready requires that.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || m_fire) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= p_v;
            end
        end else if (p_v) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_fire) begin
            if (skid_v_reg) begin
                out_lamp_reg <= skid_lamp_reg;
                out_on_reg   <= skid_on_reg;
            end else begin
                out_lamp_reg <= p_lamp;
                out_on_reg   <= p_on;
            end
        end else if (p_v) begin
            skid_lamp_reg <= p_lamp;
            skid_on_reg   <= p_on;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'b0000, out_on_reg, out_lamp_reg};

endmodule

### rtl/core/lprp_checker.sv
// Port-level checker for the LED pattern record and playback block, bound to
// the top level. Depends on lprp_pkg for the opcodes.
module lprp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [2:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A waiting result holds still until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Every result names one of the five lamps and keeps the pad bits clear.
    a_lamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] < 3'd5 && m_tdata[7:4] == 4'b0000)
        else $error("result names no lamp");

    // Commands other than tick and button edge never produce a result.
    a_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid &&
        (s_tuser == lprp_pkg::OP_START || s_tuser == lprp_pkg::OP_FAST ||
         s_tuser == lprp_pkg::OP_SLOW || s_tuser == lprp_pkg::OP_REV ||
         s_tuser > lprp_pkg::OP_REV) |=> !m_tvalid)
        else $error("command transaction produced a result");

endmodule

bind led_pattern_record_playback lprp_checker u_lprp_checker (.*);

### tb/led_pattern_record_playback_tb.sv
// Self-checking testbench for the LED pattern record and playback block.
// Needs only lprp_pkg and the led_pattern_record_playback RTL.
`timescale 1ns / 100ps

module led_pattern_record_playback_tb;

    // Sizes of the instance under test (its defaults).
    localparam int ENTRIES    = 128;
    localparam int DELAY_BITS = 20;
    localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

    // Opcodes the block has no use for; they must be swallowed silently.
    localparam logic [lprp_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [lprp_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

    // Register settings used by the run.
    localparam logic [lprp_pkg::PRESS_W-1:0] PRESS_MIN = 7'd1;
    localparam logic [lprp_pkg::PRESS_W-1:0] PRESS_MAX = 7'd64;

    // Stimulus volume and waiting budgets.
    localparam int ITEMS_FIRST   = 1000;
    localparam int ITEMS_TOTAL   = 1900;
    localparam int SETTLE_CYCLES = 2 * ENTRIES + 16;
    localparam int DRAIN_LIMIT   = 200000;

    typedef struct packed {
        logic [lprp_pkg::LAMP_W-1:0] lamp;
        logic                        lamp_on;
    } lamp_action_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_HOLD
    } rx_mode_t;

    // The board keeps its own copy of the recorder state and the register,
    // works out which lamp action each accepted input transaction causes,
    // and holds those actions until the block delivers them.
    class lamp_action_board;
        logic [lprp_pkg::PRESS_W-1:0] max_presses;
        logic                         rec_on    [ENTRIES];
        logic [lprp_pkg::LAMP_W-1:0]  rec_lamp  [ENTRIES];
        logic [DELAY_BITS-1:0]        rec_delay [ENTRIES];
        logic [7:0]                   entry_count;
        logic [lprp_pkg::PRESS_W-1:0] release_count;
        logic [DELAY_BITS-1:0]        elapsed;
        logic                         playing;
        logic [6:0]                   position;
        logic [DELAY_BITS-1:0]        wait_left;
        logic                         forward;
        lamp_action_t                 pending_actions[$];
        int errors;
        int n_inputs;
        int n_checked;
        int n_scaled;
        int n_flips;

        function new();
            max_presses   = lprp_pkg::MAX_PRESSES_RST;
            entry_count   = '0;
            release_count = '0;
            elapsed       = '0;
            playing       = 1'b0;
            position      = '0;
            wait_left     = '0;
            forward       = 1'b1;
            errors        = 0;
            n_inputs      = 0;
            n_checked     = 0;
            n_scaled      = 0;
            n_flips       = 0;
        endfunction

        function void push_action(input logic [lprp_pkg::LAMP_W-1:0] lamp,
                                  input logic lamp_on);
            lamp_action_t a;
            a.lamp    = lamp;
            a.lamp_on = lamp_on;
            pending_actions.push_back(a);
        endfunction

        // A stored delay of zero still costs one tick.
        function logic [DELAY_BITS-1:0] ticks_of(input logic [DELAY_BITS-1:0] d);
            return (d == '0) ? DELAY_BITS'(1) : d;
        endfunction

        function void play_tick();
            logic [7:0] p;
            if (wait_left > 1) begin
                wait_left = wait_left - 1'b1;
                return;
            end
            p = {1'b0, position};
            if (p >= entry_count)
                p = '0;
            push_action(rec_lamp[p], rec_on[p]);
            if (forward) begin
                p = (p + 8'd1 >= entry_count) ? 8'd0 : p + 8'd1;
                wait_left = ticks_of(rec_delay[p]);
            end else begin
                wait_left = ticks_of(rec_delay[p]);
                p = (p == 8'd0) ? entry_count - 8'd1 : p - 8'd1;
            end
            position = p[6:0];
        endfunction

        // Speed-up is 3/4, slow-down 5/4, truncated and clipped to the width.
        function void rescale(input bit faster);
            logic [DELAY_BITS+2:0] d;
            for (int i = 0; i < entry_count; i++) begin
                d = {3'b000, rec_delay[i]};
                d = faster ? ((d << 1) + d) >> 2 : ((d << 2) + d) >> 2;
                if (d > {3'b000, DELAY_MAX})
                    d = {3'b000, DELAY_MAX};
                rec_delay[i] = d[DELAY_BITS-1:0];
            end
        endfunction

        function logic [DELAY_BITS-1:0] max_delay();
            logic [DELAY_BITS-1:0] m;
            m = '0;
            for (int i = 0; i < entry_count; i++)
                if (rec_delay[i] > m)
                    m = rec_delay[i];
            return m;
        endfunction

        function void take_input(input logic [lprp_pkg::OP_W-1:0] op,
                                 input logic [2:0] btn, input logic prs);
            n_inputs++;
            case (op) inside
                lprp_pkg::OP_TICK: begin
                    if (playing)
                        play_tick();
                    else if (elapsed != DELAY_MAX)
                        elapsed = elapsed + 1'b1;
                end
                lprp_pkg::OP_EDGE: begin
                    if (!playing && btn < lprp_pkg::LAMPS && release_count < max_presses
                            && entry_count < ENTRIES) begin
                        rec_on[entry_count]    = prs;
                        rec_lamp[entry_count]  = btn;
                        rec_delay[entry_count] = elapsed;
                        entry_count = entry_count + 1'b1;
                        elapsed = '0;
                        if (!prs)
                            release_count = release_count + 1'b1;
                        push_action(btn, prs);
                    end
                end
                lprp_pkg::OP_START: begin
                    if (!playing && entry_count != 0) begin
                        playing   = 1'b1;
                        position  = '0;
                        wait_left = '0;
                    end
                end
                lprp_pkg::OP_FAST, lprp_pkg::OP_SLOW: begin
                    if (playing) begin
                        rescale(op == lprp_pkg::OP_FAST);
                        n_scaled++;
                    end
                end
                lprp_pkg::OP_REV: begin
                    if (playing) begin
                        for (int i = 0; i < entry_count; i++)
                            rec_on[i] = ~rec_on[i];
                        forward = ~forward;
                        n_flips++;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_action(input logic [lprp_pkg::LAMP_W-1:0] lamp,
                                   input logic lamp_on);
            lamp_action_t want;
            if (pending_actions.size() == 0) begin
                errors++;
                $display("%0t: lamp action with none expected: lamp %0d on %0d",
                         $time, lamp, lamp_on);
                return;
            end
            want = pending_actions.pop_front();
            n_checked++;
            if (lamp !== want.lamp) begin
                errors++;
                $display("%0t: lamp mismatch: expected %0d, actual %0d",
                         $time, want.lamp, lamp);
            end
            if (lamp_on !== want.lamp_on) begin
                errors++;
                $display("%0t: lamp_on mismatch: expected %0d, actual %0d",
                         $time, want.lamp_on, lamp_on);
            end
        endfunction
    endclass

    // Clock, reset and the block's ports. Every input starts at a known value.
    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = '0;   // [2:0] button, [3] pressed
    logic [lprp_pkg::OP_W-1:0]     s_tuser   = '0;   // [2:0] opcode
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [7:0]                    m_tdata;          // [2:0] lamp, [3] lamp_on
    logic                          cfg_wen   = 1'b0;
    logic [lprp_pkg::PRESS_W-1:0]  cfg_wdata = '0;

    lamp_action_board board = new();

    // Sender pacing: bursts of back-to-back transactions split by idle gaps.
    int burst_left = 0;

    // Receiver pacing state.
    rx_mode_t rx_mode  = RX_OPEN;
    int       rx_left  = 0;
    logic [1:0] rx_phase = '0;

    led_pattern_record_playback #(
        .ENTRIES   (ENTRIES),
        .DELAY_BITS(DELAY_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // The receiver switches between windows of random length: always ready, a
    // coin toss per cycle, ready only while a free-running two-bit phase counter
    // is zero, and a long hold that only opens at the very end of the window.
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (rx_phase == 2'd0);
            default:   m_tready <= (rx_left < 3);
        endcase
    end

    // Every result transaction is checked against the oldest expected action.
    // Outputs are sampled at the edge, before the block's own updates land.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_action(m_tdata[2:0], m_tdata[3]);
    end

    // Random button and pressed fields for transactions that ignore them.
    function automatic logic [2:0] rand_btn();
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic rand_prs();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offers one input transaction and holds it until the block takes it.
    // The board learns of it at the accepting edge, so the next choice of
    // stimulus already sees the updated recorder state.
    task automatic send_item(input logic [lprp_pkg::OP_W-1:0] op, input logic [2:0] btn,
                             input logic prs);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, prs, btn};
        do @(posedge aclk); while (!s_tready);
        board.take_input(op, btn, prs);
    endtask

    // Called right after an accepted transaction. Ends a burst with a random
    // gap; now and then a long burst runs with no gaps at all.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 20);
        gap = $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        s_tdata  <= {4'b0000, 4'($urandom)};
        s_tuser  <= 3'($urandom_range(0, 7));
        repeat (gap) @(posedge aclk);
    endtask

    // Lets every expected action drain, then gives the block time to finish
    // an action that produces no result (a ring turn or a rescale).
    task automatic settle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (board.pending_actions.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max(input logic [lprp_pkg::PRESS_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        board.max_presses = value;
        cfg_wen <= 1'b0;
    endtask

    // One recording edge with a random lamp; one in ten names a lamp that does
    // not exist. Releases stop short of the press limit so the store fills up.
    task automatic record_edge();
        logic [2:0] btn;
        logic       prs;
        btn = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
        prs = ($urandom_range(0, 9) < 6) || (board.release_count >= 60);
        send_item(lprp_pkg::OP_EDGE, btn, prs);
    endtask

    // One random playback transaction. Ticks dominate; speed changes are
    // steered so stored delays stay between a few and a few dozen ticks.
    task automatic play_item();
        int                    r;
        logic [DELAY_BITS-1:0] md;
        r = $urandom_range(0, 99);
        md = board.max_delay();
        if (r < 78)
            send_item(lprp_pkg::OP_TICK, rand_btn(), rand_prs());
        else if (r < 86) begin
            if (md > 64)
                send_item(lprp_pkg::OP_FAST, rand_btn(), rand_prs());
            else if (md < 8)
                send_item(lprp_pkg::OP_SLOW, rand_btn(), rand_prs());
            else
                send_item($urandom_range(0, 1) ? lprp_pkg::OP_FAST : lprp_pkg::OP_SLOW,
                          rand_btn(), rand_prs());
        end else if (r < 90)
            send_item(lprp_pkg::OP_REV, rand_btn(), rand_prs());
        else if (r < 92)
            send_item(lprp_pkg::OP_START, rand_btn(), rand_prs());
        else if (r < 96)
            send_item(lprp_pkg::OP_EDGE, rand_btn(), rand_prs());
        else
            send_item($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7,
                      rand_btn(), rand_prs());
    endtask

    initial begin : stimulus
        int  n;
        bit  mid_done;
        mid_done = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. While still recording with an empty store, a start,
        // the playback commands, the spare opcodes and edges on lamps that
        // do not exist must all be ignored.
        send_item(lprp_pkg::OP_START, 3'd0, 1'b0);
        send_item(lprp_pkg::OP_FAST, 3'd7, 1'b1);
        send_item(lprp_pkg::OP_SLOW, 3'd0, 1'b1);
        send_item(lprp_pkg::OP_REV, 3'd7, 1'b0);
        send_item(OP_SPARE6, 3'd7, 1'b1);
        send_item(OP_SPARE7, 3'd0, 1'b0);
        send_item(lprp_pkg::OP_EDGE, 3'd5, 1'b1);
        send_item(lprp_pkg::OP_EDGE, 3'd7, 1'b0);
        settle();

        // Smallest press limit: one press and one release get through, the
        // edges after the first release are refused.
        write_max(PRESS_MIN);
        send_item(lprp_pkg::OP_TICK, 3'd0, 1'b0);
        send_item(lprp_pkg::OP_EDGE, 3'd0, 1'b1);
        repeat (3) send_item(lprp_pkg::OP_TICK, 3'd7, 1'b1);
        send_item(lprp_pkg::OP_EDGE, 3'd4, 1'b0);
        send_item(lprp_pkg::OP_EDGE, 3'd2, 1'b1);
        send_item(lprp_pkg::OP_EDGE, 3'd3, 1'b0);
        settle();

        // Largest press limit for the rest of the recording. A long pause
        // first gives one entry a delay of about a hundred ticks.
        write_max(PRESS_MAX);
        repeat (100) begin
            send_item(lprp_pkg::OP_TICK, rand_btn(), rand_prs());
            pace();
        end
        send_item(lprp_pkg::OP_EDGE, 3'd1, 1'b1);
        pace();

        // Random recording until the store is full. Halfway, the limit is
        // pulled down to the releases seen so far, so edges bounce off it,
        // and then raised again.
        while (board.entry_count < ENTRIES) begin
            n = $urandom_range(0, 6);
            repeat (n) begin
                send_item(lprp_pkg::OP_TICK, rand_btn(), rand_prs());
                pace();
            end
            if ($urandom_range(0, 9) == 0)
                send_item(3'(lprp_pkg::OP_FAST + $urandom_range(0, 4)), rand_btn(),
                          rand_prs());
            else
                record_edge();
            pace();
            if (!mid_done && board.entry_count >= ENTRIES / 2) begin
                mid_done = 1'b1;
                settle();
                write_max(board.release_count);
                send_item(lprp_pkg::OP_EDGE, 3'd2, 1'b1);
                send_item(lprp_pkg::OP_EDGE, 3'd3, 1'b0);
                send_item(lprp_pkg::OP_EDGE, 3'd4, 1'b1);
                settle();
                write_max(PRESS_MAX);
            end
        end

        // Store full: further edges are refused even below the press limit.
        send_item(lprp_pkg::OP_EDGE, 3'd0, 1'b1);
        send_item(lprp_pkg::OP_EDGE, 3'd1, 1'b0);
        send_item(lprp_pkg::OP_START, 3'd0, 1'b0);
        pace();

        while (board.n_inputs < ITEMS_FIRST) begin
            play_item();
            pace();
        end

        // Slow down until some delay clips at the top of its width, then
        // speed up until the delays are short again. No tick runs in
        // between, so the wait in progress is never a clipped one.
        n = 0;
        while (board.max_delay() != DELAY_MAX && n < 80) begin
            send_item(lprp_pkg::OP_SLOW, rand_btn(), rand_prs());
            pace();
            n++;
        end
        n = 0;
        while (board.max_delay() > 40 && n < 80) begin
            send_item(lprp_pkg::OP_FAST, rand_btn(), rand_prs());
            pace();
            n++;
        end

        // A register write during playback must not disturb it.
        settle();
        write_max(lprp_pkg::MAX_PRESSES_RST);

        while (board.n_inputs < ITEMS_TOTAL) begin
            play_item();
            pace();
        end

        settle();
        if (board.pending_actions.size() != 0) begin
            board.errors += board.pending_actions.size();
            $display("%0t: %0d lamp actions never arrived", $time,
                     board.pending_actions.size());
        end

        $display("Run covered %0d input transactions and %0d checked lamp actions,",
                 board.n_inputs, board.n_checked);
        $display("with %0d stored entries, %0d delay rescales and %0d reversals.",
                 board.entry_count, board.n_scaled, board.n_flips);
        if (board.errors == 0)
            $display("led_pattern_record_playback_tb: done, clean");
        else
            $display("led_pattern_record_playback_tb: done, errors");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin : watchdog
        #20000000;
        $display("led_pattern_record_playback_tb: done, errors");
        $finish;
    end

endmodule
